[sv/slpl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slpl_pkg;

  localparam int DEF_MAX_BOUNDARIES     = 1024;
  localparam int DEF_MAX_EDGES          = 4096;
  localparam int DEF_MAX_SLOTS_PER_BAND = 64;

  localparam logic [1:0] OP_LOAD_BND  = 2'd0;
  localparam logic [1:0] OP_LOAD_EDGE = 2'd1;
  localparam logic [1:0] OP_LOAD_SLOT = 2'd2;
  localparam logic [1:0] OP_QUERY     = 2'd3;

  localparam logic [1:0] ST_SHARED   = 2'd0;
  localparam logic [1:0] ST_FALLBACK = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam logic [15:0] NO_TRI = 16'hFFFF;

  // sign of (edge y at query x) - query y
  typedef struct packed {
    logic gt;
    logic lt;
  } cmp_t;

endpackage

`default_nettype wire

[sv/slpl_edge_cmp.sv]
`timescale 1ns / 1ps
`default_nettype none

module slpl_edge_cmp import slpl_pkg::*; (
  input  wire logic               clk,
  input  wire logic [127:0]       edge_coords,  // x0, y0, x1, y1 from the lowest bit up
  input  wire logic signed [31:0] qx,
  input  wire logic signed [31:0] qy,
  output cmp_t                    res
);

  logic signed [31:0] x0, y0, x1, y1;
  logic signed [32:0] dx, dy0, dy, dqx;
  logic signed [65:0] p1_r, p2_r;
  logic signed [32:0] dy0_r;
  logic               dxz_r, dxneg_r;
  logic signed [66:0] sum;
  logic               pos, neg, vpos, vneg;

  assign x0 = edge_coords[31:0];
  assign y0 = edge_coords[63:32];
  assign x1 = edge_coords[95:64];
  assign y1 = edge_coords[127:96];

  assign dx  = 33'(x1) - 33'(x0);
  assign dy0 = 33'(y0) - 33'(qy);
  assign dy  = 33'(y1) - 33'(y0);
  assign dqx = 33'(qx) - 33'(x0);

  // one registered product each, summed next cycle
  always_ff @(posedge clk) begin
    p1_r    <= dy0 * dx;
    p2_r    <= dy * dqx;
    dy0_r   <= dy0;
    dxz_r   <= (dx == '0);
    dxneg_r <= dx[32];
  end

  assign sum  = 67'(p1_r) + 67'(p2_r);
  assign pos  = !sum[66] && (sum != '0);
  assign neg  = sum[66];
  assign vpos = !dy0_r[32] && (dy0_r != '0);
  assign vneg = dy0_r[32];

  always_comb begin
    if (dxz_r) begin
      res.gt = vpos;
      res.lt = vneg;
    end else if (dxneg_r) begin
      res.gt = neg;
      res.lt = pos;
    end else begin
      res.gt = pos;
      res.lt = neg;
    end
  end

endmodule

`default_nettype wire

[sv/slab_point_location_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Slab point location over a triangulated plane, Q16.16 coordinates. Load
// words (opcode on in_tuser) fill the boundary, edge and band slot tables
// straight from the idle state, back to back; a query word walks the tables
// through synchronous memories with one read port each and returns one
// result word. After reset the band count table is cleared one entry at a
// time with in_tready low. Configuration writes are taken during that pass,
// or while the block is idle and no input word is offered, never in the
// middle of a query. A query makes P boundary probes, P being about
// log2(boundary_count), each a read then a compare, then Q band probes, Q
// about log2 of the band's edge count, each a slot read, an edge read and a
// two-stage compare; a point that lies exactly on a probed edge ends the
// band search early. in_tready returns in the same cycle that the result
// word is presented. An empty band skips the band search and the triangle
// lookup and answers with triangle 0xFFFF, status 2. The next word is
// accepted while a result is still held on the output; a second query then
// waits for that output register to empty before it finishes.

module slab_point_location_core import slpl_pkg::*; #(
  parameter int MAX_BOUNDARIES     = DEF_MAX_BOUNDARIES,
  parameter int MAX_EDGES          = DEF_MAX_EDGES,
  parameter int MAX_SLOTS_PER_BAND = DEF_MAX_SLOTS_PER_BAND
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // entry_index, band_index, edge_ref, coord_x1, coord_y1, coord_x2,
  // coord_y2, tri_first, tri_second, tri_count, zero fill
  input  wire logic [199:0] in_tdata,
  input  wire logic [1:0]   in_tuser,   // opcode
  input  wire logic         in_tlast,   // last_in_band
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // triangle, edge_below, edge_above, band_found, zero fill
  output logic [55:0]       out_tdata,
  output logic [1:0]        out_tuser,  // status
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [10:0]  cfg_data    // boundary_count
);

  localparam int BW   = $clog2(MAX_BOUNDARIES);
  localparam int NW   = BW + 1;
  localparam int EW   = $clog2(MAX_EDGES);
  localparam int CW   = $clog2(MAX_SLOTS_PER_BAND);
  localparam int CNTW = $clog2(MAX_SLOTS_PER_BAND + 1);
  localparam int SAW  = $clog2(MAX_BOUNDARIES * MAX_SLOTS_PER_BAND);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RD0   = 5'd2;
  localparam logic [4:0] S_RDN   = 5'd3;
  localparam logic [4:0] S_CLAMP = 5'd4;
  localparam logic [4:0] S_BS    = 5'd5;
  localparam logic [4:0] S_BSW   = 5'd6;
  localparam logic [4:0] S_BAND  = 5'd7;
  localparam logic [4:0] S_CNT   = 5'd8;
  localparam logic [4:0] S_ES    = 5'd9;
  localparam logic [4:0] S_ESW   = 5'd10;
  localparam logic [4:0] S_EC    = 5'd11;
  localparam logic [4:0] S_ECS   = 5'd12;
  localparam logic [4:0] S_FA    = 5'd13;
  localparam logic [4:0] S_FB    = 5'd14;
  localparam logic [4:0] S_FC    = 5'd15;
  localparam logic [4:0] S_FD    = 5'd16;
  localparam logic [4:0] S_FE    = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;

  // input word fields
  logic [11:0]        f_idx, f_eref;
  logic [9:0]         f_band;
  logic signed [31:0] f_x1, f_y1;
  logic [127:0]       f_coords;
  logic [15:0]        f_t1, f_t2;
  logic [1:0]         f_tcnt;
  logic               in_acc;

  assign f_idx    = in_tdata[11:0];
  assign f_band   = in_tdata[21:12];
  assign f_eref   = in_tdata[33:22];
  assign f_x1     = in_tdata[65:34];
  assign f_y1     = in_tdata[97:66];
  assign f_coords = in_tdata[161:34];
  assign f_t1     = in_tdata[177:162];
  assign f_t2     = in_tdata[193:178];
  assign f_tcnt   = in_tdata[195:194];
  assign in_acc   = in_tvalid && in_tready;

  // tables
  logic [31:0]     bnd_mem  [MAX_BOUNDARIES];
  logic [127:0]    edge_mem [MAX_EDGES];
  logic [31:0]     tris_mem [MAX_EDGES];
  logic [11:0]     slot_mem [MAX_BOUNDARIES * MAX_SLOTS_PER_BAND];
  logic [CNTW-1:0] cnt_mem  [MAX_BOUNDARIES];

  logic signed [31:0] bnd_q;
  logic [127:0]       edge_q;
  logic [31:0]        tris_q;
  logic [11:0]        slot_q;
  logic [CNTW-1:0]    cnt_q;

  logic [BW-1:0]  bnd_ra, cnt_ra;
  logic [EW-1:0]  edge_ra, tris_ra;
  logic [SAW-1:0] slot_ra;

  // control and working registers
  logic [4:0]         state_r, state_nxt;
  logic [10:0]        bcount_r;
  logic [BW-1:0]      clr_r, clr_nxt;
  logic signed [31:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic signed [31:0] bmin_r, bmin_nxt, cx_r, cx_nxt;
  logic [NW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt;
  logic [BW-1:0]      mid_r, mid_nxt, bl_r, bl_nxt;
  logic [CW-1:0]      jl_r, jl_nxt, ju_r, ju_nxt, jm_r, jm_nxt;
  logic [11:0]        eb_r, eb_nxt, ea_r, ea_nxt;
  logic [31:0]        tb_r, tb_nxt;
  logic [15:0]        rtri_r, rtri_nxt;
  logic [1:0]         rst_r, rst_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [55:0]        odata_r, odata_nxt;
  logic [1:0]         ouser_r, ouser_nxt;

  // boundary count clamped to [2, MAX_BOUNDARIES]
  logic [NW-1:0] n_eff;
  logic [NW:0]   mid_sum;
  logic [BW-1:0] mid_c, bl_c;
  logic [NW-1:0] up_c;
  logic [CW:0]   jm_sum;
  logic [CW-1:0] jm_c;
  logic [CW:0]   jdiff;
  logic signed [31:0] cx_lo;

  // triangle pick
  logic [15:0] la, lb, ua, ub;
  logic        has_la, has_lb;

  cmp_t ecmp;

  logic slot_ok, bnd_wr, edge_wr, slot_wr, cnt_wr;
  logic [BW-1:0]   cnt_wa;
  logic [CNTW-1:0] cnt_wd;

  slpl_edge_cmp u_cmp (
    .clk         (clk),
    .edge_coords (edge_q),
    .qx          (qx_r),
    .qy          (qy_r),
    .res         (ecmp)
  );

  always_comb begin
    if (32'(bcount_r) < 2) begin
      n_eff = NW'(2);
    end else if (32'(bcount_r) > MAX_BOUNDARIES) begin
      n_eff = NW'(MAX_BOUNDARIES);
    end else begin
      n_eff = NW'(bcount_r);
    end
  end

  assign mid_sum = (NW+1)'(lo_r) + (NW+1)'(hi_r);
  assign mid_c   = BW'(mid_sum >> 1);
  assign up_c    = (lo_r == '0) ? NW'(1) : ((lo_r > n_eff - NW'(1)) ? n_eff - NW'(1) : lo_r);
  assign bl_c    = BW'(up_c - NW'(1));
  assign jm_sum  = (CW+1)'(jl_r) + (CW+1)'(ju_r);
  assign jm_c    = CW'(jm_sum >> 1);
  assign jdiff   = (CW+1)'(ju_r) - (CW+1)'(jl_r);
  assign cx_lo   = (qx_r < bmin_r) ? bmin_r : qx_r;

  assign la     = (tb_r[31:16] < tb_r[15:0]) ? tb_r[31:16] : tb_r[15:0];
  assign lb     = (tb_r[31:16] < tb_r[15:0]) ? tb_r[15:0] : tb_r[31:16];
  assign ua     = tris_q[15:0];
  assign ub     = tris_q[31:16];
  assign has_la = (la != NO_TRI) && ((ua == la) || (ub == la));
  assign has_lb = (lb != NO_TRI) && ((ua == lb) || (ub == lb));

  // load writes happen straight from the idle state
  assign slot_ok = (32'(f_band) < MAX_BOUNDARIES - 1) && (32'(f_idx) < MAX_SLOTS_PER_BAND) &&
                   (32'(f_eref) < MAX_EDGES);
  assign bnd_wr  = in_acc && (in_tuser == OP_LOAD_BND) && (32'(f_idx) < MAX_BOUNDARIES);
  assign edge_wr = in_acc && (in_tuser == OP_LOAD_EDGE) && (32'(f_idx) < MAX_EDGES);
  assign slot_wr = in_acc && (in_tuser == OP_LOAD_SLOT) && slot_ok;
  assign cnt_wr  = (state_r == S_CLR) || (slot_wr && in_tlast);
  assign cnt_wa  = (state_r == S_CLR) ? clr_r : BW'(f_band);
  assign cnt_wd  = (state_r == S_CLR) ? '0 : CNTW'(32'(f_idx) + 1);

  // read addresses
  always_comb begin
    bnd_ra  = '0;
    cnt_ra  = bl_c;
    edge_ra = EW'(slot_q);
    tris_ra = EW'(eb_r);
    slot_ra = SAW'(32'(bl_r) * MAX_SLOTS_PER_BAND + 32'(jm_c));
    case (state_r)
      S_RDN:   bnd_ra = BW'(n_eff - NW'(1));
      S_BS:    bnd_ra = mid_c;
      S_FA:    slot_ra = SAW'(32'(bl_r) * MAX_SLOTS_PER_BAND + 32'(jl_r));
      S_FB:    slot_ra = SAW'(32'(bl_r) * MAX_SLOTS_PER_BAND + 32'(ju_r));
      S_FD:    tris_ra = EW'(ea_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bnd_wr) begin
      bnd_mem[BW'(f_idx)] <= f_x1;
    end
    bnd_q <= bnd_mem[bnd_ra];
  end

  always_ff @(posedge clk) begin
    if (edge_wr) begin
      edge_mem[EW'(f_idx)] <= f_coords;
    end
    edge_q <= edge_mem[edge_ra];
  end

  // a missing second triangle is stored as the sentinel
  always_ff @(posedge clk) begin
    if (edge_wr) begin
      tris_mem[EW'(f_idx)] <= {(f_tcnt[1] ? f_t2 : NO_TRI), f_t1};
    end
    tris_q <= tris_mem[tris_ra];
  end

  always_ff @(posedge clk) begin
    if (slot_wr) begin
      slot_mem[SAW'(32'(f_band) * MAX_SLOTS_PER_BAND + 32'(f_idx))] <= f_eref;
    end
    slot_q <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_wr) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_q <= cnt_mem[cnt_ra];
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    qx_nxt     = qx_r;
    qy_nxt     = qy_r;
    bmin_nxt   = bmin_r;
    cx_nxt     = cx_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    bl_nxt     = bl_r;
    jl_nxt     = jl_r;
    ju_nxt     = ju_r;
    jm_nxt     = jm_r;
    eb_nxt     = eb_r;
    ea_nxt     = ea_r;
    tb_nxt     = tb_r;
    rtri_nxt   = rtri_r;
    rst_nxt    = rst_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + BW'(1);
        if (32'(clr_r) == MAX_BOUNDARIES - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc && (in_tuser == OP_QUERY)) begin
          qx_nxt    = f_x1;
          qy_nxt    = f_y1;
          state_nxt = S_RD0;
        end
      end
      S_RD0: state_nxt = S_RDN;
      S_RDN: begin
        bmin_nxt  = bnd_q;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        cx_nxt    = (cx_lo > bnd_q) ? bnd_q : cx_lo;
        lo_nxt    = '0;
        hi_nxt    = n_eff;
        state_nxt = S_BS;
      end
      S_BS: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_c;
          state_nxt = S_BSW;
        end else begin
          state_nxt = S_BAND;
        end
      end
      S_BSW: begin
        if (bnd_q < cx_r) begin
          lo_nxt = NW'(mid_r) + NW'(1);
        end else begin
          hi_nxt = NW'(mid_r);
        end
        state_nxt = S_BS;
      end
      S_BAND: begin
        bl_nxt    = bl_c;
        state_nxt = S_CNT;
      end
      S_CNT: begin
        if (cnt_q == '0) begin
          rtri_nxt  = NO_TRI;
          rst_nxt   = ST_EMPTY;
          eb_nxt    = '0;
          ea_nxt    = '0;
          state_nxt = S_OUT;
        end else begin
          jl_nxt    = '0;
          ju_nxt    = CW'(cnt_q - CNTW'(1));
          state_nxt = S_ES;
        end
      end
      S_ES: begin
        if (jdiff > (CW+1)'(1)) begin
          jm_nxt    = jm_c;
          state_nxt = S_ESW;
        end else begin
          state_nxt = S_FA;
        end
      end
      S_ESW: state_nxt = S_EC;
      S_EC:  state_nxt = S_ECS;
      S_ECS: begin
        if (ecmp.gt) begin
          ju_nxt    = jm_r;
          state_nxt = S_ES;
        end else if (ecmp.lt) begin
          jl_nxt    = jm_r;
          state_nxt = S_ES;
        end else begin
          jl_nxt    = jm_r;
          ju_nxt    = jm_r + CW'(1);
          state_nxt = S_FA;
        end
      end
      S_FA: state_nxt = S_FB;
      S_FB: begin
        eb_nxt    = slot_q;
        state_nxt = S_FC;
      end
      S_FC: begin
        ea_nxt    = slot_q;
        state_nxt = S_FD;
      end
      S_FD: begin
        tb_nxt    = tris_q;
        state_nxt = S_FE;
      end
      S_FE: begin
        if (has_la) begin
          rtri_nxt = la;
          rst_nxt  = ST_SHARED;
        end else if (has_lb) begin
          rtri_nxt = lb;
          rst_nxt  = ST_SHARED;
        end else begin
          rtri_nxt = la;
          rst_nxt  = ST_FALLBACK;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {6'b0, bl_r[9:0], ea_r, eb_r, rtri_r};
          ouser_nxt  = rst_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      bcount_r <= 11'd2;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_valid && cfg_ready) begin
        bcount_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    qx_r    <= qx_nxt;
    qy_r    <= qy_nxt;
    bmin_r  <= bmin_nxt;
    cx_r    <= cx_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    bl_r    <= bl_nxt;
    jl_r    <= jl_nxt;
    ju_r    <= ju_nxt;
    jm_r    <= jm_nxt;
    eb_r    <= eb_nxt;
    ea_r    <= ea_nxt;
    tb_r    <= tb_nxt;
    rtri_r  <= rtri_nxt;
    rst_r   <= rst_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

  // boundary count writes only in the clearing pass or between queries, never beside an offered input word
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_CLR) || ((state_r == S_IDLE) && !in_tvalid);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

`ifndef ASSERT_OFF
  a_bnd_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BS) |-> (lo_r <= hi_r))
    else $error("boundary search window inverted");

  a_slot_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ES) |-> (jl_r <= ju_r))
    else $error("band search window inverted");

  a_empty_tri: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_EMPTY)) |-> (out_tdata[15:0] == NO_TRI))
    else $error("empty band without sentinel triangle");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_CLR && state_r == S_IDLE) |-> $past(!out_tvalid))
    else $error("result present during clearing pass");
`endif

endmodule

`default_nettype wire
